// ===== rtl/core/assert_macros.svh =====
// assertion helpers for the block, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/tcac_pkg.sv =====
`timescale 1ns / 1ps
package tcac_pkg;

    // command codes
    typedef enum logic [1:0] {
        CMD_TICK      = 2'd0,
        CMD_SET_ALARM = 2'd1,
        CMD_SET_TIME  = 2'd2,
        CMD_READ_TIME = 2'd3
    } t_cmd;

    localparam int SEC_W   = 32;
    localparam int NSEC_W  = 30;
    localparam int COUNT_W = 46;

    localparam logic [30:0] TICK_NS    = 31'd200000;
    localparam logic [30:0] NS_PER_SEC = 31'd1000000000;
    localparam logic [17:0] HALF_TICK  = 18'd100000;
    localparam logic [44:0] TICKS_PER_SEC = 45'd5000;

    // nsec / 200000 == (nsec >> 6) / 3125, done with a reciprocal
    localparam int          RECIP_SHIFT = 36;
    localparam logic [48:0] RECIP       = 49'd21990232;
    localparam logic [24:0] DIV_K       = 25'd3125;

    // one command word as it moves down the pipe
    typedef struct packed {
        logic               valid;
        t_cmd               cmd;
        logic [SEC_W-1:0]   sec;
        logic [NSEC_W-1:0]  nsec;
    } t_item;

    // status seen by the top level checks
    typedef struct packed {
        logic armed;
        logic upd;
    } t_status;

endpackage

// ===== rtl/core/tcac_count.sv =====
`timescale 1ns / 1ps
module tcac_count
    import tcac_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  t_item              i_item,
    output t_item              o_item,
    output logic [COUNT_W-1:0] o_count
);

    t_item        r_s1, r_s2, r_s3, r_s4;
    logic [44:0]  r_secprod2, r_secprod3;
    logic [48:0]  r_recprod;
    logic [12:0]  r_q0;
    logic [12:0]  r_rem0;
    logic [COUNT_W-1:0] r_count;

    logic [12:0]  w_q0;
    logic [24:0]  w_sub;
    logic [12:0]  w_q;
    logic [12:0]  w_rem_full;
    logic [11:0]  w_rem;
    logic [17:0]  w_frac;
    logic         w_round;

    // stage 3: quotient estimate and remainder
    assign w_q0  = r_recprod[RECIP_SHIFT +: 13];
    assign w_sub = {1'b0, r_s2.nsec[NSEC_W-1:6]} - ({12'd0, w_q0} * DIV_K);

    // stage 4: one correction step and rounding
    always_comb begin
        if (r_rem0 >= 13'd3125) begin
            w_q        = r_q0 + 13'd1;
            w_rem_full = r_rem0 - 13'd3125;
        end else begin
            w_q        = r_q0;
            w_rem_full = r_rem0;
        end
        w_rem   = w_rem_full[11:0];
        w_frac  = {w_rem, r_s3.nsec[5:0]};
        w_round = (w_frac >= HALF_TICK);
    end

    // valid bits and payload stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
            r_s3.valid <= 1'b0;
            r_s4.valid <= 1'b0;
        end else if (i_en) begin
            r_s1.valid <= i_item.valid;
            r_s2.valid <= r_s1.valid;
            r_s3.valid <= r_s2.valid;
            r_s4.valid <= r_s3.valid;
        end
        if (i_en) begin
            r_s1.cmd  <= i_item.cmd;
            r_s1.sec  <= i_item.sec;
            r_s1.nsec <= i_item.nsec;

            r_s2.cmd   <= r_s1.cmd;
            r_s2.sec   <= r_s1.sec;
            r_s2.nsec  <= r_s1.nsec;
            r_secprod2 <= {13'd0, r_s1.sec} * TICKS_PER_SEC;
            r_recprod  <= {25'd0, r_s1.nsec[NSEC_W-1:6]} * RECIP;

            r_s3.cmd   <= r_s2.cmd;
            r_s3.sec   <= r_s2.sec;
            r_s3.nsec  <= r_s2.nsec;
            r_secprod3 <= r_secprod2;
            r_q0       <= w_q0;
            r_rem0     <= w_sub[12:0];

            r_s4.cmd  <= r_s3.cmd;
            r_s4.sec  <= r_s3.sec;
            r_s4.nsec <= r_s3.nsec;
            r_count   <= {1'b0, r_secprod3} + {33'd0, w_q} + {45'd0, w_round};
        end
    end

    assign o_item  = r_s4;
    assign o_count = r_count;

endmodule

// ===== rtl/core/tcac_state.sv =====
`timescale 1ns / 1ps
module tcac_state
    import tcac_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  t_item              i_item,
    input  logic [COUNT_W-1:0] i_count,
    output logic               o_valid,
    output logic               o_fired,
    output logic [SEC_W-1:0]   o_sec,
    output logic [NSEC_W-1:0]  o_nsec,
    output t_status            o_status
);

    logic [SEC_W-1:0]   r_sec, n_sec;
    logic [NSEC_W-1:0]  r_nsec, n_nsec;
    logic               r_armed, n_armed;
    logic [COUNT_W-1:0] r_ticks, n_ticks;
    logic               n_fired;
    logic               r_out_valid, r_out_fired, r_upd;
    logic [SEC_W-1:0]   r_out_sec;
    logic [NSEC_W-1:0]  r_out_nsec;
    logic [30:0]        w_ns;

    assign w_ns = {1'b0, r_nsec} + TICK_NS;

    // next clock and alarm state for one command
    always_comb begin
        n_sec   = r_sec;
        n_nsec  = r_nsec;
        n_armed = r_armed;
        n_ticks = r_ticks;
        n_fired = 1'b0;
        unique case (i_item.cmd)
            CMD_TICK: begin
                if (w_ns >= NS_PER_SEC) begin
                    n_nsec = NSEC_W'(w_ns - NS_PER_SEC);
                    n_sec  = r_sec + 32'd1;
                end else begin
                    n_nsec = w_ns[NSEC_W-1:0];
                end
                if (r_armed) begin
                    if (r_ticks <= 46'd1) begin
                        n_fired = 1'b1;
                        n_armed = 1'b0;
                    end
                    if (r_ticks != '0) begin
                        n_ticks = r_ticks - 46'd1;
                    end
                end
            end
            CMD_SET_ALARM: begin
                n_ticks = i_count;
                n_armed = 1'b1;
            end
            CMD_SET_TIME: begin
                n_sec  = i_item.sec;
                n_nsec = i_item.nsec;
                if (r_armed) begin
                    n_fired = 1'b1;
                    n_armed = 1'b0;
                end
            end
            CMD_READ_TIME: begin
            end
            default: begin
            end
        endcase
    end

    // state and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec       <= '0;
            r_nsec      <= '0;
            r_armed     <= 1'b0;
            r_ticks     <= '0;
            r_out_valid <= 1'b0;
            r_upd       <= 1'b0;
        end else begin
            r_upd <= i_en && i_item.valid;
            if (i_en) begin
                r_out_valid <= i_item.valid;
                if (i_item.valid) begin
                    r_sec   <= n_sec;
                    r_nsec  <= n_nsec;
                    r_armed <= n_armed;
                    r_ticks <= n_ticks;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_en && i_item.valid) begin
            r_out_fired <= n_fired;
            r_out_sec   <= n_sec;
            r_out_nsec  <= n_nsec;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_fired        = r_out_fired;
    assign o_sec          = r_out_sec;
    assign o_nsec         = r_out_nsec;
    assign o_status.armed = r_armed;
    assign o_status.upd   = r_upd;

endmodule

// ===== rtl/core/tick_clock_with_alarm_countdown.sv =====
`timescale 1ns / 1ps
// tick-driven seconds/nanoseconds clock with a one-shot alarm countdown
// input channel s_axis: one command word per handshake, command code in tuser,
// seconds and nanoseconds (alarm delay or new time) in tdata
// output channel m_axis: exactly one word per command, holding the fire flag
// and the clock as it stands after that command
// a command accepted on s_axis passes the four stages that work out the alarm
// count, then the state registers update and drive m_axis_tvalid
// throughput: one command per cycle unless m_axis stalls; the clock and
// countdown registers are read and written in the same cycle, so commands follow freely
// stall: while a result waits on m_axis the whole pipe holds and s_axis_tready
// drops; it rises again in the cycle the result is taken
// reset (i_rst_n low, synchronous): clock zero, alarm disarmed, count zero,
// pipe emptied
`include "assert_macros.svh"
module tick_clock_with_alarm_countdown
    import tcac_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // time_sec[31:0], time_nsec[61:32], zero pad
    input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // alarm_fired[0], clock_sec[32:1], clock_nsec[62:33]
);

    t_item              w_in_item;
    t_item              w_cnt_item;
    logic [COUNT_W-1:0] w_count;
    logic               w_en;
    logic               w_out_valid;
    logic               w_fired;
    logic [SEC_W-1:0]   w_sec;
    logic [NSEC_W-1:0]  w_nsec;
    t_status            w_status;

    // pipe advances unless a result is stuck at the output
    assign w_en          = !w_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    // unpack the input word
    assign w_in_item.valid = s_axis_tvalid;
    assign w_in_item.cmd   = t_cmd'(s_axis_tuser);
    assign w_in_item.sec   = s_axis_tdata[31:0];
    assign w_in_item.nsec  = s_axis_tdata[61:32];

    tcac_count u_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_item  (w_in_item),
        .o_item  (w_cnt_item),
        .o_count (w_count)
    );

    tcac_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_item   (w_cnt_item),
        .i_count  (w_count),
        .o_valid  (w_out_valid),
        .o_fired  (w_fired),
        .o_sec    (w_sec),
        .o_nsec   (w_nsec),
        .o_status (w_status)
    );

    // pack the result word
    assign m_axis_tvalid = w_out_valid;
    assign m_axis_tdata  = {1'b0, w_nsec, w_sec, w_fired};

    // checks
    `ASSERT_IMPL(a_fire_disarms, i_clk, i_rst_n, w_status.upd && w_fired, !w_status.armed)
    `ASSERT_IMPL(a_fire_needs_arm, i_clk, i_rst_n, w_status.upd && !$past(w_status.armed), !w_fired)
    `ASSERT_IMPL(a_stall_blocks_in, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready)

endmodule
